// ===== sv/cfa_pkg.sv =====
// cfa_pkg: shared types, opcodes, status codes and width helpers for the
// constant folding ALU. No dependencies.
package cfa_pkg;

    // Opcodes
    localparam logic [5:0] OP_ADD       = 6'd0;
    localparam logic [5:0] OP_SUB       = 6'd1;
    localparam logic [5:0] OP_MUL       = 6'd2;
    localparam logic [5:0] OP_SDIV      = 6'd3;
    localparam logic [5:0] OP_UDIV      = 6'd4;
    localparam logic [5:0] OP_SREM      = 6'd5;
    localparam logic [5:0] OP_UREM      = 6'd6;
    localparam logic [5:0] OP_AND       = 6'd7;
    localparam logic [5:0] OP_OR        = 6'd8;
    localparam logic [5:0] OP_XOR       = 6'd9;
    localparam logic [5:0] OP_SHL       = 6'd10;
    localparam logic [5:0] OP_SHR_S     = 6'd11;
    localparam logic [5:0] OP_SHR_U     = 6'd12;
    localparam logic [5:0] OP_NEG       = 6'd13;
    localparam logic [5:0] OP_NOT       = 6'd14;
    localparam logic [5:0] OP_EQ        = 6'd15;
    localparam logic [5:0] OP_NE        = 6'd16;
    localparam logic [5:0] OP_SLT       = 6'd17;
    localparam logic [5:0] OP_SLE       = 6'd18;
    localparam logic [5:0] OP_SGT       = 6'd19;
    localparam logic [5:0] OP_SGE       = 6'd20;
    localparam logic [5:0] OP_ULT       = 6'd21;
    localparam logic [5:0] OP_ULE       = 6'd22;
    localparam logic [5:0] OP_UGT       = 6'd23;
    localparam logic [5:0] OP_UGE       = 6'd24;
    localparam logic [5:0] OP_TRUNC     = 6'd25;
    localparam logic [5:0] OP_ZEXT      = 6'd26;
    localparam logic [5:0] OP_SEXT      = 6'd27;
    localparam logic [5:0] OP_MULH_S    = 6'd28;
    localparam logic [5:0] OP_MULH_U    = 6'd29;
    localparam logic [5:0] OP_ADD_SAT_S = 6'd30;
    localparam logic [5:0] OP_ADD_SAT_U = 6'd31;
    localparam logic [5:0] OP_SUB_SAT_S = 6'd32;
    localparam logic [5:0] OP_SUB_SAT_U = 6'd33;
    localparam logic [5:0] OP_MUL_SAT_S = 6'd34;
    localparam logic [5:0] OP_MUL_SAT_U = 6'd35;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_UNK  = 2'd3;

    // Width codes
    localparam logic [1:0] W8  = 2'd0;
    localparam logic [1:0] W16 = 2'd1;
    localparam logic [1:0] W32 = 2'd2;
    localparam logic [1:0] W64 = 2'd3;

    // Result type codes for the C types
    localparam logic [2:0] RT_LONG  = 3'd4;
    localparam logic [2:0] RT_WCHAR = 3'd5;

    // Execution class
    localparam logic [1:0] CLS_ALU = 2'd0;
    localparam logic [1:0] CLS_MUL = 2'd1;
    localparam logic [1:0] CLS_DIV = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [5:0]  cmd;
        logic [1:0]  operand_width;
        logic [2:0]  result_type;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_rsp;

    // Decoded request as it travels from front to back
    typedef struct packed {
        logic [5:0]  cmd;
        logic [1:0]  wc;      // operand width code
        logic [1:0]  rwc;     // resolved result width code
        logic [1:0]  status;
        logic [1:0]  cls;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ta;      // zero-extended at operand width
        logic [63:0] tb;
        logic [63:0] sa;      // sign-extended at operand width
        logic [63:0] sb;
    } t_op;

    function automatic logic [63:0] mask_w(input logic [63:0] v, input logic [1:0] wc);
        case (wc)
            W8:      mask_w = {56'b0, v[7:0]};
            W16:     mask_w = {48'b0, v[15:0]};
            W32:     mask_w = {32'b0, v[31:0]};
            default: mask_w = v;
        endcase
    endfunction

    function automatic logic [63:0] sext_w(input logic [63:0] v, input logic [1:0] wc);
        case (wc)
            W8:      sext_w = {{56{v[7]}}, v[7:0]};
            W16:     sext_w = {{48{v[15]}}, v[15:0]};
            W32:     sext_w = {{32{v[31]}}, v[31:0]};
            default: sext_w = v;
        endcase
    endfunction

    function automatic logic [63:0] shr_w(input logic [63:0] v, input logic [1:0] wc);
        case (wc)
            W8:      shr_w = v >> 8;
            W16:     shr_w = v >> 16;
            W32:     shr_w = v >> 32;
            default: shr_w = 64'b0;
        endcase
    endfunction

    function automatic logic [63:0] smax_w(input logic [1:0] wc);
        case (wc)
            W8:      smax_w = 64'h7F;
            W16:     smax_w = 64'h7FFF;
            W32:     smax_w = 64'h7FFF_FFFF;
            default: smax_w = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    // Clamp a sign-extended value into the signed range of the width
    function automatic logic [63:0] clamp_s(input logic [63:0] r, input logic [1:0] wc);
        logic [63:0] smax;
        logic [63:0] smin;
        smax = smax_w(wc);
        smin = ~smax;
        if ($signed(smax) < $signed(r)) begin
            clamp_s = smax;
        end else if ($signed(r) < $signed(smin)) begin
            clamp_s = smin;
        end else begin
            clamp_s = r;
        end
    endfunction

endpackage

// ===== sv/cfa_front.sv =====
// cfa_front: holds the long_is_32 register and decodes each request into
// an execution class, early status and width-adjusted operands. Uses cfa_pkg.
module cfa_front import cfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_data,
    input  t_req        i_req,
    output t_op         o_op
);

    logic        r_long;
    logic [1:0]  wc;
    logic [63:0] ta;
    logic [63:0] tb;
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] minbit;
    logic        is_div;
    logic        is_sdiv;
    logic        is_mul;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long <= 1'b0;
        end else if (i_cfg_valid) begin
            r_long <= i_cfg_data;
        end
    end

    assign wc     = i_req.operand_width;
    assign ta     = mask_w(i_req.operand_a, wc);
    assign tb     = mask_w(i_req.operand_b, wc);
    assign sa     = sext_w(i_req.operand_a, wc);
    assign sb     = sext_w(i_req.operand_b, wc);
    assign minbit = smax_w(wc) + 64'd1;

    assign is_div  = (i_req.cmd == OP_SDIV) || (i_req.cmd == OP_UDIV) ||
                     (i_req.cmd == OP_SREM) || (i_req.cmd == OP_UREM);
    assign is_sdiv = (i_req.cmd == OP_SDIV) || (i_req.cmd == OP_SREM);
    assign is_mul  = (i_req.cmd == OP_MUL) || (i_req.cmd == OP_MULH_S) ||
                     (i_req.cmd == OP_MULH_U) || (i_req.cmd == OP_MUL_SAT_S) ||
                     (i_req.cmd == OP_MUL_SAT_U);

    // Classify, set early status and resolve widths
    always_comb begin
        o_op.cmd = i_req.cmd;
        o_op.wc  = wc;
        o_op.a   = i_req.operand_a;
        o_op.b   = i_req.operand_b;
        o_op.ta  = ta;
        o_op.tb  = tb;
        o_op.sa  = sa;
        o_op.sb  = sb;

        case (i_req.result_type)
            RT_LONG:  o_op.rwc = r_long ? W32 : W64;
            RT_WCHAR: o_op.rwc = r_long ? W16 : W32;
            3'd0:     o_op.rwc = W8;
            3'd1:     o_op.rwc = W16;
            3'd2:     o_op.rwc = W32;
            default:  o_op.rwc = W64;
        endcase

        if (i_req.cmd > OP_MUL_SAT_U) begin
            o_op.status = ST_UNK;
        end else if (is_div && (tb == 64'b0)) begin
            o_op.status = ST_DIV0;
        end else if (is_sdiv && (ta == minbit) && (sb == '1)) begin
            o_op.status = ST_OVF;
        end else begin
            o_op.status = ST_OK;
        end

        if (o_op.status != ST_OK) begin
            o_op.cls = CLS_ALU;
        end else if (is_div) begin
            o_op.cls = CLS_DIV;
        end else if (is_mul) begin
            o_op.cls = CLS_MUL;
        end else begin
            o_op.cls = CLS_ALU;
        end
    end

endmodule

// ===== sv/cfa_queue.sv =====
// cfa_queue: small FIFO of decoded requests between front and back.
// Uses cfa_pkg.
module cfa_queue import cfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_op   i_op,
    input  logic  i_pop,
    output t_op   o_op,
    output logic  o_vld,
    output logic  o_full
);

    t_op                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QPTR_W:0]    r_cnt;

    assign o_vld  = (r_cnt != '0);
    assign o_full = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_op   = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/cfa_back.sv =====
// cfa_back: execution unit. ALU ops registered at issue, a 32x32 partial-product
// multiplier sequence and a radix-2 divider. Uses cfa_pkg.
module cfa_back import cfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_op   i_op,
    output logic  o_pop,
    output logic  o_done,
    output t_rsp  o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]   r_state;
    t_op          r_cur;
    logic [2:0]   r_ph;
    logic [5:0]   r_cnt;
    logic [63:0]  r_x;
    logic [63:0]  r_y;
    logic         r_sgn;
    logic [63:0]  r_prod;
    logic [1:0]   r_psh;
    logic [127:0] r_acc;
    logic [63:0]  r_quo;
    logic [63:0]  r_rem;
    logic [63:0]  r_dvs;
    logic         r_out_vld;
    t_rsp         r_out;

    logic [63:0]  alu_v;
    logic [63:0]  fin_v;
    logic [63:0]  n_x;
    logic [63:0]  n_y;
    logic         n_sgn;
    logic [31:0]  x_part;
    logic [31:0]  y_part;
    logic [127:0] prod_sh;
    logic [64:0]  div_t;
    logic [64:0]  div_d;
    logic [64:0]  div_r;
    logic         div_ge;
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic [63:0]  umax;
    logic [63:0]  sum_r;
    logic [63:0]  dif_r;
    logic [5:0]   sh;

    assign o_pop  = (r_state == S_IDLE) && i_vld;
    assign o_done = r_out_vld;
    assign o_rsp  = r_out;

    // Combinational ALU operations
    assign sh   = i_op.b[5:0];
    assign umax = mask_w('1, i_op.wc);
    always_comb begin
        sum_r = 64'b0;
        dif_r = 64'b0;
        case (i_op.cmd)
            OP_ADD:    alu_v = i_op.a + i_op.b;
            OP_SUB:    alu_v = i_op.a - i_op.b;
            OP_AND:    alu_v = i_op.a & i_op.b;
            OP_OR:     alu_v = i_op.a | i_op.b;
            OP_XOR:    alu_v = i_op.a ^ i_op.b;
            OP_SHL:    alu_v = i_op.a << sh;
            OP_SHR_S:  alu_v = $unsigned($signed(i_op.sa) >>> sh);
            OP_SHR_U:  alu_v = i_op.ta >> sh;
            OP_NEG:    alu_v = 64'b0 - i_op.a;
            OP_NOT:    alu_v = ~i_op.a;
            OP_EQ:     alu_v = {63'b0, i_op.ta == i_op.tb};
            OP_NE:     alu_v = {63'b0, i_op.ta != i_op.tb};
            OP_SLT:    alu_v = {63'b0, $signed(i_op.sa) < $signed(i_op.sb)};
            OP_SLE:    alu_v = {63'b0, $signed(i_op.sa) <= $signed(i_op.sb)};
            OP_SGT:    alu_v = {63'b0, $signed(i_op.sa) > $signed(i_op.sb)};
            OP_SGE:    alu_v = {63'b0, $signed(i_op.sa) >= $signed(i_op.sb)};
            OP_ULT:    alu_v = {63'b0, i_op.ta < i_op.tb};
            OP_ULE:    alu_v = {63'b0, i_op.ta <= i_op.tb};
            OP_UGT:    alu_v = {63'b0, i_op.ta > i_op.tb};
            OP_UGE:    alu_v = {63'b0, i_op.ta >= i_op.tb};
            OP_TRUNC,
            OP_ZEXT:   alu_v = i_op.ta;
            OP_SEXT:   alu_v = i_op.sa;
            OP_ADD_SAT_S: begin
                sum_r = i_op.sa + i_op.sb;
                if (((i_op.sa ^ sum_r) & (i_op.sb ^ sum_r)) >> 63 != 64'b0) begin
                    alu_v = i_op.sa[63] ? ~smax_w(i_op.wc) : smax_w(i_op.wc);
                end else begin
                    alu_v = clamp_s(sum_r, i_op.wc);
                end
            end
            OP_ADD_SAT_U: begin
                sum_r = i_op.ta + i_op.tb;
                alu_v = ((sum_r < i_op.ta) || (sum_r > umax)) ? umax : sum_r;
            end
            OP_SUB_SAT_S: begin
                dif_r = i_op.sa - i_op.sb;
                if (((i_op.sa ^ i_op.sb) & (i_op.sa ^ dif_r)) >> 63 != 64'b0) begin
                    alu_v = i_op.sa[63] ? ~smax_w(i_op.wc) : smax_w(i_op.wc);
                end else begin
                    alu_v = clamp_s(dif_r, i_op.wc);
                end
            end
            OP_SUB_SAT_U: alu_v = (i_op.ta < i_op.tb) ? 64'b0 : i_op.ta - i_op.tb;
            default:   alu_v = 64'b0;
        endcase
    end

    // Multiplier operand selection at issue
    assign n_sgn = (i_op.cmd == OP_MULH_S) || (i_op.cmd == OP_MUL_SAT_S);
    assign n_x   = (i_op.cmd == OP_MUL) ? i_op.a : (n_sgn ? i_op.sa : i_op.ta);
    assign n_y   = (i_op.cmd == OP_MUL) ? i_op.b : (n_sgn ? i_op.sb : i_op.tb);

    // Partial product halves and alignment
    assign x_part = r_ph[0] ? r_x[63:32] : r_x[31:0];
    assign y_part = r_ph[1] ? r_y[63:32] : r_y[31:0];
    always_comb begin
        case (r_psh)
            2'd0:    prod_sh = {64'b0, r_prod};
            2'd1:    prod_sh = {32'b0, r_prod, 32'b0};
            default: prod_sh = {r_prod, 64'b0};
        endcase
    end

    // Divider step
    assign div_t  = {r_rem, r_quo[63]};
    assign div_d  = {1'b0, r_dvs};
    assign div_r  = div_t - div_d;
    assign div_ge = (div_t >= div_d);

    // Final value for multiply and divide ops
    assign hi = r_acc[127:64];
    assign lo = r_acc[63:0];
    always_comb begin
        case (r_cur.cmd)
            OP_MUL:    fin_v = lo;
            OP_MULH_S: fin_v = (r_cur.wc == W64) ? hi : sext_w(shr_w(lo, r_cur.wc), r_cur.wc);
            OP_MULH_U: fin_v = (r_cur.wc == W64) ? hi : mask_w(shr_w(lo, r_cur.wc), r_cur.wc);
            OP_MUL_SAT_S: begin
                if (hi != {64{lo[63]}}) begin
                    fin_v = (r_x[63] != r_y[63]) ? ~smax_w(r_cur.wc) : smax_w(r_cur.wc);
                end else begin
                    fin_v = clamp_s(lo, r_cur.wc);
                end
            end
            OP_MUL_SAT_U: begin
                fin_v = ((hi != 64'b0) || (lo > mask_w('1, r_cur.wc))) ?
                        mask_w('1, r_cur.wc) : lo;
            end
            OP_SDIV:   fin_v = (r_cur.sa[63] != r_cur.sb[63]) ? 64'b0 - r_quo : r_quo;
            OP_UDIV:   fin_v = r_quo;
            OP_SREM:   fin_v = r_cur.sa[63] ? 64'b0 - r_rem : r_rem;
            OP_UREM:   fin_v = r_rem;
            default:   fin_v = 64'b0;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_ph      <= '0;
            r_cnt     <= '0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_vld) begin
                        r_cur <= i_op;
                        case (i_op.cls)
                            CLS_MUL: begin
                                r_x     <= n_x;
                                r_y     <= n_y;
                                r_sgn   <= n_sgn;
                                r_acc   <= '0;
                                r_ph    <= '0;
                                r_state <= S_MUL;
                            end
                            CLS_DIV: begin
                                if (i_op.cmd == OP_SDIV || i_op.cmd == OP_SREM) begin
                                    r_quo <= i_op.sa[63] ? 64'b0 - i_op.sa : i_op.sa;
                                    r_dvs <= i_op.sb[63] ? 64'b0 - i_op.sb : i_op.sb;
                                end else begin
                                    r_quo <= i_op.ta;
                                    r_dvs <= i_op.tb;
                                end
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_out_vld    <= 1'b1;
                                r_out.status <= i_op.status;
                                r_out.value  <= (i_op.status == ST_OK) ?
                                                mask_w(alu_v, i_op.rwc) : 64'b0;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    // products on phases 0..3, accumulate on 1..4, sign fixes 5..6
                    if (r_ph <= 3'd3) begin
                        r_prod <= {32'b0, x_part} * {32'b0, y_part};
                        r_psh  <= {1'b0, r_ph[0]} + {1'b0, r_ph[1]};
                    end
                    if (r_ph >= 3'd1 && r_ph <= 3'd4) begin
                        r_acc <= r_acc + prod_sh;
                    end else if (r_ph == 3'd5) begin
                        r_acc[127:64] <= hi - ((r_sgn && r_x[63]) ? r_y : 64'b0);
                    end else if (r_ph == 3'd6) begin
                        r_acc[127:64] <= hi - ((r_sgn && r_y[63]) ? r_x : 64'b0);
                    end
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd6) begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? div_r[63:0] : div_t[63:0];
                    r_quo <= {r_quo[62:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out_vld    <= 1'b1;
                    r_out.status <= ST_OK;
                    r_out.value  <= mask_w(fin_v, r_cur.rwc);
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/constant_fold_alu.sv =====
// constant_fold_alu: 64-bit folding ALU, top level. Front decode, request
// queue and back execution unit. Uses cfa_pkg, cfa_front, cfa_queue, cfa_back.
// Multiply forms use four 32x32 partial products plus sign fix; divide and
// remainder produce one quotient bit per cycle. Throughput: one request per
// cycle for logic, add, compare, shift, saturating add-sub and other ALU-class
// ops; the back unit is held by a multiply or divide.
// Synchronous active-low reset clears the queue, sequencer and long_is_32.
module constant_fold_alu import cfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    output logic  o_done,
    output t_rsp  o_rsp,
    input  logic  i_cfg_valid,
    output logic  o_cfg_ready,
    input  logic  i_cfg_data
);

    t_op  front_op;
    t_op  q_op;
    logic q_vld;
    logic q_full;
    logic pop;
    logic push;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;
    assign push        = start && !q_full;

    cfa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .o_op        (front_op)
    );

    cfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (q_op),
        .o_vld   (q_vld),
        .o_full  (q_full)
    );

    cfa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_op    (q_op),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== sv/cfa_checker.sv =====
// cfa_checker: port-level assertions for constant_fold_alu, bound to the
// top level. Uses cfa_pkg.
module cfa_checker import cfa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_done,
    input t_rsp o_rsp,
    input logic o_cfg_ready
);

    // Reset drops the result strobe
    a_rst_done: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    // Reset empties the queue
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy after reset");

    // Faulted results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |-> (o_rsp.value == 64'b0))
        else $error("nonzero value on error status");

    // Config port never stalls
    a_cfg_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("config port not ready");

endmodule

bind constant_fold_alu cfa_checker u_cfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_done      (o_done),
    .o_rsp       (o_rsp),
    .o_cfg_ready (o_cfg_ready)
);
